@@ hdl/arbm_pkg.sv @@
package arbm_pkg;

    // ring geometry
    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 12;
    localparam int ACC_W    = 24;
    localparam int VOL_W    = 16;
    localparam int FILL_W   = 12;

    // width that holds both a pointer distance and a chunk length
    localparam int SPAN_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    // product: signed sample times zero-extended volume
    localparam int PROD_W  = SAMPLE_W + VOL_W + 1;
    localparam int SHIFT   = 6;
    localparam int SCALE_W = PROD_W - SHIFT;
    localparam int SUM_W   = ((SCALE_W > ACC_W) ? SCALE_W : ACC_W) + 1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_MIX   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam ptr_t PTR_LAST = ptr_t'(RING_DEPTH - 1);

    function automatic ptr_t ring_next(input ptr_t p);
        ring_next = (p == PTR_LAST) ? '0 : ptr_t'(p + ptr_t'(1));
    endfunction

    // (a - b) mod RING_DEPTH
    function automatic ptr_t ring_diff(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] wrap;
        wrap = {1'b0, a} + (PTR_W+1)'(RING_DEPTH) - {1'b0, b};
        ring_diff = (a >= b) ? ptr_t'(a - b) : wrap[PTR_W-1:0];
    endfunction

endpackage

@@ hdl/audio_ring_buffer_mixer.sv @@
// Channel   Handshake            Payload
// -------   ------------------   --------------------------------------------------
// command   start && !busy       opcode, sample_in, chunk_length, mix_in, volume,
//                                last_of_run
// result    done (one cycle)     mixed_out, mix_valid, write_accepted, fill_level
//
// Write, flush and the unused opcode are decoded on the accepting edge and their
// result shows in the following cycle. A mix passes the store's registered read and
// the register after the multiplier (states S_MUL and S_ACC) before its result shows.
// Reset clears pointers and chunk/mix flags; the sample store is not cleared.
// The receiver cannot stall: done is a single-cycle strobe, busy only reflects work.
module audio_ring_buffer_mixer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [arbm_pkg::OP_W-1:0]           opcode,
    input  logic signed [arbm_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [arbm_pkg::LEN_W-1:0]          chunk_length,
    input  logic signed [arbm_pkg::ACC_W-1:0]   mix_in,
    input  logic [arbm_pkg::VOL_W-1:0]          volume,
    input  logic                                last_of_run,
    output logic                                done,
    output logic signed [arbm_pkg::ACC_W-1:0]   mixed_out,
    output logic                                mix_valid,
    output logic                                write_accepted,
    output logic [arbm_pkg::FILL_W-1:0]         fill_level
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ACC  = 2'd2;

    localparam int PTR_W  = arbm_pkg::PTR_W;
    localparam int SPAN_W = arbm_pkg::SPAN_W;

    localparam logic signed [arbm_pkg::SUM_W-1:0] ACC_MAX =
        arbm_pkg::SUM_W'((2 ** (arbm_pkg::ACC_W - 1)) - 1);
    localparam logic signed [arbm_pkg::SUM_W-1:0] ACC_MIN =
        -arbm_pkg::SUM_W'(2 ** (arbm_pkg::ACC_W - 1));
    localparam logic [SPAN_W-1:0] FILL_MAX = SPAN_W'((2 ** arbm_pkg::FILL_W) - 1);

    // sample store: one write port, one registered read port
    logic signed [arbm_pkg::SAMPLE_W-1:0] mem [arbm_pkg::RING_DEPTH];
    logic signed [arbm_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic [1:0] state_reg;

    // ring pointers and run tracking
    arbm_pkg::ptr_t head_reg, tail_reg, read_reg, write_reg;
    logic           chunk_open_reg, chunk_ok_reg, mix_open_reg;
    logic [arbm_pkg::LEN_W-1:0] chunk_left_reg;

    // mix pipeline
    logic signed [arbm_pkg::ACC_W-1:0]  acc_reg;
    logic [arbm_pkg::VOL_W-1:0]         vol_reg;
    logic                               avail_reg;
    logic signed [arbm_pkg::PROD_W-1:0] prod_reg;

    // results
    logic                               done_reg;
    logic signed [arbm_pkg::ACC_W-1:0]  mixed_reg;
    logic                               mix_valid_reg;
    logic                               waccept_reg;

    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // ---- write chunk decode ----
    arbm_pkg::ptr_t              free_diff, free_sp, wr_ptr, wr_ptr_next;
    logic                        wr_ok, wr_store;
    logic [arbm_pkg::LEN_W-1:0]  wr_left, wr_left_next;

    always_comb
    begin
        free_diff = arbm_pkg::ring_diff(tail_reg, head_reg);
        free_sp   = (free_diff == '0) ? arbm_pkg::PTR_LAST
                                      : PTR_W'(free_diff - arbm_pkg::ptr_t'(1));
        if (!chunk_open_reg)
        begin
            wr_ok   = SPAN_W'(chunk_length) <= SPAN_W'(free_sp);
            wr_left = chunk_length;
            wr_ptr  = head_reg;
        end
        else
        begin
            wr_ok   = chunk_ok_reg;
            wr_left = chunk_left_reg;
            wr_ptr  = write_reg;
        end
        wr_store     = wr_ok && (wr_left != '0);
        wr_ptr_next  = wr_store ? arbm_pkg::ring_next(wr_ptr) : wr_ptr;
        wr_left_next = wr_store ? arbm_pkg::LEN_W'(wr_left - 1'b1) : wr_left;
    end

    // ---- mix decode ----
    arbm_pkg::ptr_t rd_ptr, rd_ptr_next;
    logic           rd_avail;

    always_comb
    begin
        rd_ptr      = mix_open_reg ? read_reg : tail_reg;
        rd_avail    = (head_reg != rd_ptr);
        rd_ptr_next = rd_avail ? arbm_pkg::ring_next(rd_ptr) : rd_ptr;
    end

    logic is_write;
    assign is_write = accept && (arbm_pkg::opcode_t'(opcode) == arbm_pkg::OP_WRITE);

    always_ff @(posedge clk)
    begin
        if (is_write && wr_store)
        begin
            mem[wr_ptr] <= sample_in;
        end
        rd_data_reg <= mem[rd_ptr];
    end

    // ---- control and pointers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            read_reg       <= '0;
            write_reg      <= '0;
            chunk_open_reg <= 1'b0;
            chunk_ok_reg   <= 1'b0;
            chunk_left_reg <= '0;
            mix_open_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (arbm_pkg::opcode_t'(opcode))
                            arbm_pkg::OP_WRITE:
                            begin
                                done_reg  <= 1'b1;
                                write_reg <= wr_ptr_next;
                                if (last_of_run)
                                begin
                                    if (wr_ok)
                                    begin
                                        head_reg <= wr_ptr_next;
                                    end
                                    chunk_open_reg <= 1'b0;
                                    chunk_ok_reg   <= 1'b0;
                                    chunk_left_reg <= '0;
                                end
                                else
                                begin
                                    chunk_open_reg <= 1'b1;
                                    chunk_ok_reg   <= wr_ok;
                                    chunk_left_reg <= wr_left_next;
                                end
                            end
                            arbm_pkg::OP_MIX:
                            begin
                                state_reg <= S_MUL;
                                read_reg  <= rd_ptr_next;
                                if (last_of_run)
                                begin
                                    tail_reg     <= rd_ptr_next;
                                    mix_open_reg <= 1'b0;
                                end
                                else
                                begin
                                    mix_open_reg <= 1'b1;
                                end
                            end
                            arbm_pkg::OP_FLUSH:
                            begin
                                done_reg       <= 1'b1;
                                head_reg       <= '0;
                                tail_reg       <= '0;
                                read_reg       <= '0;
                                write_reg      <= '0;
                                chunk_open_reg <= 1'b0;
                                chunk_ok_reg   <= 1'b0;
                                chunk_left_reg <= '0;
                                mix_open_reg   <= 1'b0;
                            end
                            arbm_pkg::OP_NONE:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---- datapath ----
    logic signed [arbm_pkg::PROD_W-1:0]  prod_rnd;
    logic signed [arbm_pkg::SCALE_W-1:0] scaled;
    logic signed [arbm_pkg::SUM_W-1:0]   sum;
    logic signed [arbm_pkg::ACC_W-1:0]   sum_sat;

    always_comb
    begin
        // round half up, floor shift
        prod_rnd = prod_reg + arbm_pkg::PROD_W'(2 ** (arbm_pkg::SHIFT - 1));
        scaled   = prod_rnd[arbm_pkg::PROD_W-1:arbm_pkg::SHIFT];
        sum      = arbm_pkg::SUM_W'(acc_reg) + arbm_pkg::SUM_W'(scaled);
        priority if (sum > ACC_MAX)
        begin
            sum_sat = ACC_MAX[arbm_pkg::ACC_W-1:0];
        end
        else if (sum < ACC_MIN)
        begin
            sum_sat = ACC_MIN[arbm_pkg::ACC_W-1:0];
        end
        else
        begin
            sum_sat = sum[arbm_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg   <= mix_in;
            vol_reg   <= volume;
            avail_reg <= rd_avail;
            // non-mix transactions report zero and the flag for a stored sample
            mixed_reg     <= '0;
            mix_valid_reg <= 1'b0;
            waccept_reg   <= is_write && wr_store;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= rd_data_reg * $signed({1'b0, vol_reg});
        end
        if (state_reg == S_ACC)
        begin
            mixed_reg     <= avail_reg ? sum_sat : acc_reg;
            mix_valid_reg <= avail_reg;
        end
    end

    // committed fill from the live pointers; they only move on an accepting edge
    logic [SPAN_W-1:0] fill_span;
    assign fill_span = SPAN_W'(arbm_pkg::ring_diff(head_reg, tail_reg));

    assign done           = done_reg;
    assign mixed_out      = mixed_reg;
    assign mix_valid      = mix_valid_reg;
    assign write_accepted = waccept_reg;
    assign fill_level     = (fill_span > FILL_MAX) ? FILL_MAX[arbm_pkg::FILL_W-1:0]
                                                   : fill_span[arbm_pkg::FILL_W-1:0];

endmodule
